/* design/tls_sni_pkg.sv */
// Package for the TLS ClientHello SNI parser: payload structs, phase codes,
// verdict codes and the front-to-back word type. No dependencies.
`default_nettype none
package tls_sni_pkg;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
    logic       last_available;
  } in_word_t;

  typedef struct packed {
    logic       name_byte_valid;
    logic [7:0] name_char;
    logic       verdict_valid;
    logic [1:0] verdict_code;
  } out_word_t;

  typedef enum logic [4:0] {
    PH_HS_HEAD, PH_SKIP_RANDOM, PH_SID_LEN, PH_SKIP_SID, PH_CIPH_LEN, PH_SKIP_CIPH,
    PH_COMP_LEN, PH_SKIP_COMP, PH_EXTS_LEN, PH_EXT_CHECK, PH_EXT_TYPE, PH_SNI_LEN,
    PH_OTHER_LEN, PH_SKIP_EXT, PH_LIST_LEN, PH_NAME_CHECK, PH_NAME_TYPE, PH_HOST_LEN,
    PH_OTHERNAME_LEN, PH_SKIP_NAME, PH_HOST, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {PV_NONE, PV_FOUND, PV_NOTFOUND, PV_FATAL} pend_t;

  localparam logic [1:0] VC_FOUND    = 2'd0;
  localparam logic [1:0] VC_NOTFOUND = 2'd1;
  localparam logic [1:0] VC_NEEDMORE = 2'd2;

  localparam logic [7:0]  REC_TYPE_HS  = 8'd22;
  localparam logic [7:0]  REC_MAJOR    = 8'd3;
  localparam logic [7:0]  HS_CLIENT_HI = 8'd1;
  localparam logic [16:0] POS_MAX      = 17'h1FFFF;
  localparam logic [16:0] RANDOM_END   = 17'd38;
  localparam logic [16:0] MIN_HS_END   = 17'd39;
  localparam logic [8:0]  MAX_HOST     = 9'd253;
  localparam logic [6:0]  MAX_LABEL    = 7'd63;
  localparam logic [2:0]  HDR_LEN      = 3'd5;

  // front to back: one handshake byte with record-layer bookkeeping done
  typedef struct packed {
    logic       hs_byte;     // byte goes to the handshake parser
    logic       rec_end;     // record closes on this byte
    logic       hdr_bad;     // bad record header judged on this byte
    logic       last;
    logic       restart;     // clear handshake state before this byte
    logic [7:0] data;
  } fb_word_t;

endpackage
`default_nettype wire

/* design/tls_client_hello_sni_parser.sv */
// Top level of the TLS ClientHello SNI parser: front and back stages.
// Depends on tls_sni_pkg, tls_sni_front and tls_sni_back.
//
// One stream byte is accepted per clock while in_stall is low. Each byte
// is registered by the record framing stage and again by the ClientHello
// walker before its result word appears; each stage holds one word and
// stall on the result side stops both stages in turn. At most one result
// word per byte: a lowercased hostname byte, a verdict, or both.
`default_nettype none
module tls_client_hello_sni_parser (
  input  wire  logic                   clk,
  input  wire  logic                   rst_n,
  input  wire  logic                   in_valid,
  output logic                         in_stall,
  input  wire  tls_sni_pkg::in_word_t  in_data,
  output logic                         out_valid,
  input  wire  logic                   out_stall,
  output tls_sni_pkg::out_word_t       out_data
);
  logic                  fw_valid, fw_stall;
  tls_sni_pkg::fb_word_t fw_data;

  tls_sni_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .fw_valid, .fw_stall, .fw_data
  );

  tls_sni_back u_back (
    .clk, .rst_n, .fw_valid, .fw_stall, .fw_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

/* design/tls_sni_front.sv */
// Front stage: record header stripping and record body framing.
// Uses tls_sni_pkg. Emits one fb_word_t per accepted input byte.
`default_nettype none
module tls_sni_front (
  input  wire  logic                   clk,
  input  wire  logic                   rst_n,
  input  wire  logic                   in_valid,
  output logic                         in_stall,
  input  wire  tls_sni_pkg::in_word_t  in_data,
  output logic                         fw_valid,
  input  wire  logic                   fw_stall,
  output tls_sni_pkg::fb_word_t        fw_data
);
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [15:0] left_r, left_nxt;
  logic        bad_r, bad_nxt;
  logic        vld_r;
  tls_sni_pkg::fb_word_t w_r, w_nxt;
  logic        acc;
  logic [2:0]  hc;
  logic [15:0] lf;
  logic        bd;

  assign in_stall = vld_r && fw_stall;
  assign acc      = in_valid && !in_stall;
  assign fw_valid = vld_r;
  assign fw_data  = w_r;

  always_comb begin
    hc = in_data.first_byte ? 3'd0 : hcnt_r;
    lf = in_data.first_byte ? 16'd0 : left_r;
    bd = in_data.first_byte ? 1'b0 : bad_r;
    hcnt_nxt = hc;
    left_nxt = lf;
    bad_nxt  = bd;
    w_nxt = '0;
    w_nxt.data    = in_data.data_byte;
    w_nxt.last    = in_data.last_available;
    w_nxt.restart = in_data.first_byte;
    if (hc < tls_sni_pkg::HDR_LEN) begin
      hcnt_nxt = hc + 3'd1;
      case (hc)
        3'd0: bad_nxt = (in_data.data_byte != tls_sni_pkg::REC_TYPE_HS);
        3'd1: if (in_data.data_byte != tls_sni_pkg::REC_MAJOR) bad_nxt = 1'b1;
        3'd3: left_nxt = {in_data.data_byte, 8'd0};
        3'd4: begin
          left_nxt = {lf[15:8], in_data.data_byte};
          if (bd) w_nxt.hdr_bad = 1'b1;
          else if ({lf[15:8], in_data.data_byte} == 16'd0) begin
            hcnt_nxt = 3'd0;
            w_nxt.rec_end = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      w_nxt.hs_byte = 1'b1;
      left_nxt = lf - 16'd1;
      if (lf == 16'd1) begin
        hcnt_nxt = 3'd0;
        w_nxt.rec_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
      left_r <= '0;
      bad_r  <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (acc) begin
        hcnt_r <= hcnt_nxt;
        left_r <= left_nxt;
        bad_r  <= bad_nxt;
        vld_r  <= 1'b1;
      end else if (!fw_stall) begin
        vld_r <= 1'b0;
      end
    end
    if (acc) w_r <= w_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fw_valid && fw_stall |=> fw_valid && $stable(fw_data))
    else $error("front word lost while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    fw_valid |-> !(fw_data.hs_byte && fw_data.hdr_bad))
    else $error("body byte flagged as header");
  assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= tls_sni_pkg::HDR_LEN)
    else $error("header count out of range");
endmodule
`default_nettype wire

/* design/tls_sni_back.sv */
// Back stage: ClientHello walk, hostname checks and verdicts.
// Uses tls_sni_pkg. Takes fb_word_t words, drives the result channel.
`default_nettype none
module tls_sni_back (
  input  wire  logic                   clk,
  input  wire  logic                   rst_n,
  input  wire  logic                   fw_valid,
  output logic                         fw_stall,
  input  wire  tls_sni_pkg::fb_word_t  fw_data,
  output logic                         out_valid,
  input  wire  logic                   out_stall,
  output tls_sni_pkg::out_word_t       out_data
);
  tls_sni_pkg::phase_t ph_r, ph_nxt;
  tls_sni_pkg::pend_t  pv_r, pv_nxt;
  logic [16:0] pos_r, pos_nxt, end_r, end_nxt, ext_r, ext_nxt, item_r, item_nxt;
  logic [16:0] lst_r, lst_nxt;
  logic [23:0] sh_r, sh_nxt;
  logic [8:0]  hl_r, hl_nxt;
  logic [6:0]  ll_r, ll_nxt;
  logic        las_r, las_nxt, fin_r, fin_nxt;
  logic        ov_r;
  tls_sni_pkg::out_word_t o_r, o_nxt;
  logic        acc;

  // working copies
  tls_sni_pkg::phase_t ph;
  tls_sni_pkg::pend_t  pv;
  logic [16:0] p, np, en, ex, it, ls;
  logic [23:0] sh, v24;
  logic [8:0]  hl;
  logic [6:0]  ll;
  logic        las, fin, emit, vv;
  logic [1:0]  vc;
  logic [7:0]  b, c;
  logic        alnum;
  logic [17:0] s1, s2;

  assign fw_stall  = ov_r && out_stall;
  assign acc       = fw_valid && !fw_stall;
  assign out_valid = ov_r;
  assign out_data  = o_r;

  always_comb begin
    ph = ph_r; pv = pv_r; p = pos_r; en = end_r; ex = ext_r; it = item_r; ls = lst_r;
    sh = sh_r; hl = hl_r; ll = ll_r; las = las_r; fin = fin_r;
    if (fw_data.restart) begin
      ph = tls_sni_pkg::PH_HS_HEAD; pv = tls_sni_pkg::PV_NONE; p = '0; en = '0;
      ex = '0; it = '0; ls = '0; sh = '0; hl = '0; ll = '0; las = 1'b1; fin = 1'b0;
    end
    b = fw_data.data;
    emit = 1'b0; vv = 1'b0; vc = tls_sni_pkg::VC_FOUND;
    c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
    np = (p < tls_sni_pkg::POS_MAX) ? p + 17'd1 : p;
    v24 = {sh[15:0], b};
    s1 = '0; s2 = '0;
    if (!fin && fw_data.hs_byte) begin
      case (ph)
        tls_sni_pkg::PH_HS_HEAD: begin
          if (p == 17'd0) begin
            if (b != tls_sni_pkg::HS_CLIENT_HI) begin
              pv = tls_sni_pkg::PV_FATAL; ph = tls_sni_pkg::PH_DONE;
            end
          end else begin
            sh = v24;
            if (p == 17'd3) begin
              if (v24 > 24'hFFFF) begin
                pv = tls_sni_pkg::PV_FATAL; ph = tls_sni_pkg::PH_DONE;
              end else begin
                en = v24[16:0] + 17'd4;
                if (en < tls_sni_pkg::MIN_HS_END) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ph = tls_sni_pkg::PH_SKIP_RANDOM; it = tls_sni_pkg::RANDOM_END;
                end
              end
            end
          end
        end
        tls_sni_pkg::PH_SID_LEN: begin
          s1 = {1'b0, np} + {10'd0, b} + 18'd2;
          if (s1 > {1'b0, en}) begin
            pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
          end else begin
            ph = tls_sni_pkg::PH_SKIP_SID; it = np + {9'd0, b};
          end
        end
        tls_sni_pkg::PH_COMP_LEN: begin
          s1 = {1'b0, np} + {10'd0, b};
          if (s1 == {1'b0, en} || s1 + 18'd2 > {1'b0, en}) begin
            pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
          end else begin
            ph = tls_sni_pkg::PH_SKIP_COMP; it = s1[16:0];
          end
        end
        tls_sni_pkg::PH_NAME_TYPE: begin
          ph = (b == 8'd0) ? tls_sni_pkg::PH_HOST_LEN : tls_sni_pkg::PH_OTHERNAME_LEN;
          it = np + 17'd2; sh = '0;
        end
        tls_sni_pkg::PH_CIPH_LEN, tls_sni_pkg::PH_EXTS_LEN, tls_sni_pkg::PH_EXT_TYPE,
        tls_sni_pkg::PH_OTHER_LEN, tls_sni_pkg::PH_SNI_LEN, tls_sni_pkg::PH_LIST_LEN,
        tls_sni_pkg::PH_OTHERNAME_LEN, tls_sni_pkg::PH_HOST_LEN: begin
          sh = v24;
          if (np == it) begin
            // field values reach at most 16 bits here
            s1 = {1'b0, np} + {2'd0, v24[15:0]};
            case (ph)
              tls_sni_pkg::PH_CIPH_LEN:
                if (s1 + 18'd1 > {1'b0, en}) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ph = tls_sni_pkg::PH_SKIP_CIPH; it = s1[16:0];
                end
              tls_sni_pkg::PH_EXTS_LEN:
                if (s1 > {1'b0, en}) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ex = s1[16:0]; ph = tls_sni_pkg::PH_EXT_CHECK;
                end
              tls_sni_pkg::PH_EXT_TYPE: begin
                ph = (v24[15:0] == 16'd0) ? tls_sni_pkg::PH_SNI_LEN
                                          : tls_sni_pkg::PH_OTHER_LEN;
                it = np + 17'd2; sh = '0;
              end
              tls_sni_pkg::PH_OTHER_LEN:
                if (s1 > {1'b0, ex}) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ph = tls_sni_pkg::PH_SKIP_EXT; it = s1[16:0];
                end
              tls_sni_pkg::PH_SNI_LEN:
                if (s1 > {1'b0, ex} || v24[15:0] < 16'd5) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ls = s1[16:0]; ph = tls_sni_pkg::PH_LIST_LEN;
                  it = np + 17'd2; sh = '0;
                end
              tls_sni_pkg::PH_LIST_LEN:
                if (s1 > {1'b0, ls}) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ls = s1[16:0]; ph = tls_sni_pkg::PH_NAME_CHECK;
                end
              tls_sni_pkg::PH_OTHERNAME_LEN:
                if (s1 > {1'b0, ls}) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  ph = tls_sni_pkg::PH_SKIP_NAME; it = s1[16:0];
                end
              default:
                if (s1 > {1'b0, ls} || v24[15:0] == 16'd0 || v24[15:0] > 16'd253) begin
                  pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
                end else begin
                  hl = v24[8:0]; las = 1'b1; ll = '0; ph = tls_sni_pkg::PH_HOST;
                end
            endcase
          end
        end
        tls_sni_pkg::PH_HOST: begin
          if (c == 8'h2E && las) begin
            pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
          end else if (c != 8'h2E && !(alnum || c == 8'h2D)) begin
            pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
          end else if (c != 8'h2E && ll >= tls_sni_pkg::MAX_LABEL) begin
            pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
          end else begin
            if (c == 8'h2E) begin
              las = 1'b1; ll = '0;
            end else begin
              las = 1'b0; ll = ll + 7'd1;
            end
            emit = 1'b1;
            hl = hl - 9'd1;
            if (hl == 9'd0) begin
              pv = las ? tls_sni_pkg::PV_NOTFOUND : tls_sni_pkg::PV_FOUND;
              ph = tls_sni_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
      p = np;
      // settle: skips resolve, and at most one extension or name check follows
      case (ph)
        tls_sni_pkg::PH_SKIP_RANDOM:
          if (p == it) ph = tls_sni_pkg::PH_SID_LEN;
        tls_sni_pkg::PH_SKIP_SID:
          if (p == it) begin ph = tls_sni_pkg::PH_CIPH_LEN; it = p + 17'd2; sh = '0; end
        tls_sni_pkg::PH_SKIP_CIPH:
          if (p == it) ph = tls_sni_pkg::PH_COMP_LEN;
        tls_sni_pkg::PH_SKIP_COMP:
          if (p == it) begin ph = tls_sni_pkg::PH_EXTS_LEN; it = p + 17'd2; sh = '0; end
        tls_sni_pkg::PH_SKIP_EXT:
          if (p == it) ph = tls_sni_pkg::PH_EXT_CHECK;
        tls_sni_pkg::PH_SKIP_NAME:
          if (p == it) ph = tls_sni_pkg::PH_NAME_CHECK;
        default: ;
      endcase
      s2 = {1'b0, p} + 18'd4;
      if (ph == tls_sni_pkg::PH_EXT_CHECK) begin
        if (s2 > {1'b0, ex}) begin
          pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
        end else begin
          ph = tls_sni_pkg::PH_EXT_TYPE; it = p + 17'd2; sh = '0;
        end
      end else if (ph == tls_sni_pkg::PH_NAME_CHECK) begin
        if (s2 - 18'd1 > {1'b0, ls}) begin
          pv = tls_sni_pkg::PV_NOTFOUND; ph = tls_sni_pkg::PH_DONE;
        end else begin
          ph = tls_sni_pkg::PH_NAME_TYPE;
        end
      end
    end
    if (!fin) begin
      if (fw_data.hdr_bad) begin
        vv = 1'b1; vc = tls_sni_pkg::VC_NOTFOUND;
      end else if (fw_data.rec_end && p >= 17'd4) begin
        if (pv == tls_sni_pkg::PV_FATAL) begin
          vv = 1'b1; vc = tls_sni_pkg::VC_NOTFOUND;
        end else if (p >= en) begin
          vv = 1'b1;
          vc = (pv == tls_sni_pkg::PV_FOUND) ? tls_sni_pkg::VC_FOUND
                                             : tls_sni_pkg::VC_NOTFOUND;
        end
      end
      if (!vv && fw_data.last) begin
        vv = 1'b1; vc = tls_sni_pkg::VC_NEEDMORE;
      end
      if (vv) fin = 1'b1;
    end
    ph_nxt = ph; pv_nxt = pv; pos_nxt = p; end_nxt = en; ext_nxt = ex; item_nxt = it;
    lst_nxt = ls; sh_nxt = sh; hl_nxt = hl; ll_nxt = ll; las_nxt = las; fin_nxt = fin;
    o_nxt.name_byte_valid = emit;
    o_nxt.name_char       = emit ? c : 8'd0;
    o_nxt.verdict_valid   = vv;
    o_nxt.verdict_code    = vv ? vc : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= tls_sni_pkg::PH_HS_HEAD; pv_r <= tls_sni_pkg::PV_NONE;
      pos_r <= '0; end_r <= '0; ext_r <= '0; item_r <= '0; lst_r <= '0;
      sh_r <= '0; hl_r <= '0; ll_r <= '0; las_r <= 1'b1; fin_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (acc) begin
        ph_r <= ph_nxt; pv_r <= pv_nxt; pos_r <= pos_nxt; end_r <= end_nxt;
        ext_r <= ext_nxt; item_r <= item_nxt; lst_r <= lst_nxt; sh_r <= sh_nxt;
        hl_r <= hl_nxt; ll_r <= ll_nxt; las_r <= las_nxt; fin_r <= fin_nxt;
        ov_r <= o_nxt.name_byte_valid || o_nxt.verdict_valid;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
    if (acc) o_r <= o_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.name_byte_valid || out_data.verdict_valid)
    else $error("empty result word");
  assert property (@(posedge clk) disable iff (!rst_n)
    ll_r <= tls_sni_pkg::MAX_LABEL)
    else $error("label length overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    hl_r <= tls_sni_pkg::MAX_HOST)
    else $error("host length overrun");
endmodule
`default_nettype wire

/* bench/tls_client_hello_sni_parser_tb.sv */
// Testbench for tls_client_hello_sni_parser: builds TLS record streams that carry
// ClientHello messages, predicts each result word, and checks the DUT output.
// Depends on tls_sni_pkg and the DUT.
`default_nettype none
module tls_client_hello_sni_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  tls_sni_pkg::in_word_t  in_data;
  logic                   out_valid;
  logic                   out_stall;
  tls_sni_pkg::out_word_t out_data;

  tls_client_hello_sni_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 150;

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // ---- predictor state ----
  tls_sni_pkg::phase_t ph;
  tls_sni_pkg::pend_t  pend;
  int unsigned rhc, rbl, pos, hs_end, ext_end, item_end, list_end, lsh;
  int unsigned host_left, lab_len;
  bit          lab_start, done_conn, hdr_bad;

  tls_sni_pkg::out_word_t expected_words[$];
  tls_sni_pkg::in_word_t  conn_q[$];
  int        mismatches = 0;
  int        in_taken = 0;
  int        out_taken = 0;
  int        items_sent = 0;
  bit        no_idle = 0;
  bit        hold_req = 0;

  function automatic void sni_reset();
    ph = tls_sni_pkg::PH_HS_HEAD; pend = tls_sni_pkg::PV_NONE;
    rhc = 0; rbl = 0; pos = 0; hs_end = 0; ext_end = 0; item_end = 0;
    list_end = 0; lsh = 0; host_left = 0; lab_len = 0;
    lab_start = 1; done_conn = 0; hdr_bad = 0;
  endfunction

  function automatic void sni_decide(tls_sni_pkg::pend_t v);
    pend = v;
    ph = tls_sni_pkg::PH_DONE;
  endfunction

  function automatic void sni_field(tls_sni_pkg::phase_t p, int unsigned n);
    ph = p;
    item_end = pos + n;
    lsh = 0;
  endfunction

  function automatic void sni_skip(tls_sni_pkg::phase_t p, int unsigned t);
    ph = p;
    item_end = t;
  endfunction

  // resolve empty skips and loop bound checks
  function automatic void sni_settle();
    bit again;
    do begin
      again = 0;
      case (ph)
        tls_sni_pkg::PH_SKIP_RANDOM:
          if (pos == item_end) ph = tls_sni_pkg::PH_SID_LEN;
        tls_sni_pkg::PH_SKIP_SID:
          if (pos == item_end) sni_field(tls_sni_pkg::PH_CIPH_LEN, 2);
        tls_sni_pkg::PH_SKIP_CIPH:
          if (pos == item_end) ph = tls_sni_pkg::PH_COMP_LEN;
        tls_sni_pkg::PH_SKIP_COMP:
          if (pos == item_end) sni_field(tls_sni_pkg::PH_EXTS_LEN, 2);
        tls_sni_pkg::PH_SKIP_EXT: if (pos == item_end) begin
          ph = tls_sni_pkg::PH_EXT_CHECK;
          again = 1;
        end
        tls_sni_pkg::PH_EXT_CHECK: begin
          if (pos + 4 > ext_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
          else sni_field(tls_sni_pkg::PH_EXT_TYPE, 2);
        end
        tls_sni_pkg::PH_SKIP_NAME: if (pos == item_end) begin
          ph = tls_sni_pkg::PH_NAME_CHECK;
          again = 1;
        end
        tls_sni_pkg::PH_NAME_CHECK: begin
          if (pos + 3 > list_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
          else ph = tls_sni_pkg::PH_NAME_TYPE;
        end
        default: ;
      endcase
    end while (again);
  endfunction

  function automatic void sni_length_done(int unsigned v, int unsigned np);
    case (ph)
      tls_sni_pkg::PH_CIPH_LEN: begin
        if (np + v + 1 > hs_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else sni_skip(tls_sni_pkg::PH_SKIP_CIPH, np + v);
      end
      tls_sni_pkg::PH_EXTS_LEN: begin
        if (np + v > hs_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else begin
          ext_end = np + v;
          ph = tls_sni_pkg::PH_EXT_CHECK;
        end
      end
      tls_sni_pkg::PH_EXT_TYPE:
        sni_field((v == 0) ? tls_sni_pkg::PH_SNI_LEN : tls_sni_pkg::PH_OTHER_LEN, 2);
      tls_sni_pkg::PH_OTHER_LEN: begin
        if (np + v > ext_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else sni_skip(tls_sni_pkg::PH_SKIP_EXT, np + v);
      end
      tls_sni_pkg::PH_SNI_LEN: begin
        if (np + v > ext_end || v < 5) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else begin
          list_end = np + v;
          sni_field(tls_sni_pkg::PH_LIST_LEN, 2);
        end
      end
      tls_sni_pkg::PH_LIST_LEN: begin
        if (np + v > list_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else begin
          list_end = np + v;
          ph = tls_sni_pkg::PH_NAME_CHECK;
        end
      end
      tls_sni_pkg::PH_OTHERNAME_LEN: begin
        if (np + v > list_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else sni_skip(tls_sni_pkg::PH_SKIP_NAME, np + v);
      end
      tls_sni_pkg::PH_HOST_LEN: begin
        if (np + v > list_end || v == 0 || v > tls_sni_pkg::MAX_HOST)
          sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else begin
          host_left = v;
          lab_start = 1;
          lab_len = 0;
          ph = tls_sni_pkg::PH_HOST;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit sni_hs_byte(int unsigned b, output logic [7:0] ch);
    int unsigned p, np, c;
    bit emit, alnum, bad;
    p = pos;
    emit = 0;
    ch = '0;
    if (pos < tls_sni_pkg::POS_MAX) pos++;
    np = pos;
    case (ph)
      tls_sni_pkg::PH_HS_HEAD: begin
        if (p == 0) begin
          if (b != tls_sni_pkg::HS_CLIENT_HI) sni_decide(tls_sni_pkg::PV_FATAL);
        end else begin
          lsh = ((lsh << 8) | b) & 24'hFFFFFF;
          if (p == 3) begin
            if (lsh > 16'hFFFF) sni_decide(tls_sni_pkg::PV_FATAL);
            else begin
              hs_end = 4 + lsh;
              if (hs_end < tls_sni_pkg::MIN_HS_END) sni_decide(tls_sni_pkg::PV_NOTFOUND);
              else sni_skip(tls_sni_pkg::PH_SKIP_RANDOM, tls_sni_pkg::RANDOM_END);
            end
          end
        end
      end
      tls_sni_pkg::PH_SID_LEN: begin
        if (np + b + 2 > hs_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else sni_skip(tls_sni_pkg::PH_SKIP_SID, np + b);
      end
      tls_sni_pkg::PH_COMP_LEN: begin
        if (np + b == hs_end || np + b + 2 > hs_end) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else sni_skip(tls_sni_pkg::PH_SKIP_COMP, np + b);
      end
      tls_sni_pkg::PH_NAME_TYPE:
        sni_field((b == 0) ? tls_sni_pkg::PH_HOST_LEN : tls_sni_pkg::PH_OTHERNAME_LEN, 2);
      tls_sni_pkg::PH_CIPH_LEN, tls_sni_pkg::PH_EXTS_LEN, tls_sni_pkg::PH_EXT_TYPE,
      tls_sni_pkg::PH_OTHER_LEN, tls_sni_pkg::PH_SNI_LEN, tls_sni_pkg::PH_LIST_LEN,
      tls_sni_pkg::PH_OTHERNAME_LEN, tls_sni_pkg::PH_HOST_LEN: begin
        lsh = ((lsh << 8) | b) & 24'hFFFFFF;
        if (np == item_end) sni_length_done(lsh, np);
      end
      tls_sni_pkg::PH_HOST: begin
        c = (b >= "A" && b <= "Z") ? b + 32 : b;
        alnum = (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
        bad = 0;
        if (c == ".") begin
          if (lab_start) bad = 1;
          else begin
            lab_start = 1;
            lab_len = 0;
          end
        end else if (alnum || c == "-") begin
          if (lab_len >= tls_sni_pkg::MAX_LABEL) bad = 1;
          else begin
            lab_start = 0;
            lab_len++;
          end
        end else bad = 1;
        if (bad) sni_decide(tls_sni_pkg::PV_NOTFOUND);
        else begin
          emit = 1;
          ch = c[7:0];
          host_left--;
          if (host_left == 0)
            sni_decide(lab_start ? tls_sni_pkg::PV_NOTFOUND : tls_sni_pkg::PV_FOUND);
        end
      end
      default: ;
    endcase
    sni_settle();
    return emit;
  endfunction

  function automatic void sni_record_end(inout bit vv, inout logic [1:0] vc);
    if (pos < 4) return;
    if (pend == tls_sni_pkg::PV_FATAL) begin
      vv = 1;
      vc = tls_sni_pkg::VC_NOTFOUND;
    end else if (pos >= hs_end) begin
      vv = 1;
      vc = (pend == tls_sni_pkg::PV_FOUND) ? tls_sni_pkg::VC_FOUND
                                           : tls_sni_pkg::VC_NOTFOUND;
    end
  endfunction

  function automatic void sni_predict(tls_sni_pkg::in_word_t w);
    int unsigned k, b;
    bit nv, vv;
    logic [1:0] vc;
    logic [7:0] nc;
    tls_sni_pkg::out_word_t o;
    nv = 0; vv = 0; vc = '0; nc = '0;
    b = w.data_byte;
    if (w.first_byte) sni_reset();
    if (done_conn) return;
    if (rhc < tls_sni_pkg::HDR_LEN) begin
      k = rhc;
      rhc = k + 1;
      if (k == 0) hdr_bad = (b != tls_sni_pkg::REC_TYPE_HS);
      else if (k == 1) begin
        if (b != tls_sni_pkg::REC_MAJOR) hdr_bad = 1;
      end else if (k == 3) rbl = b << 8;
      else if (k == 4) begin
        rbl = rbl | b;
        if (hdr_bad) begin
          vv = 1;
          vc = tls_sni_pkg::VC_NOTFOUND;
        end else if (rbl == 0) begin
          rhc = 0;
          sni_record_end(vv, vc);
        end
      end
    end else begin
      nv = sni_hs_byte(b, nc);
      rbl = (rbl - 1) & 16'hFFFF;
      if (rbl == 0) begin
        rhc = 0;
        sni_record_end(vv, vc);
      end
    end
    if (!vv && w.last_available) begin
      vv = 1;
      vc = tls_sni_pkg::VC_NEEDMORE;
    end
    if (vv) done_conn = 1;
    if (!nv && !vv) return;
    o.name_byte_valid = nv;
    o.name_char = nv ? nc : 8'd0;
    o.verdict_valid = vv;
    o.verdict_code = vv ? vc : 2'd0;
    expected_words.push_back(o);
  endfunction

  // ---- input side ----
  task automatic send_word(tls_sni_pkg::in_word_t w);
    int gap;
    bit ok;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    ok = 0;
    do begin
      @(negedge clk);
      ok = !in_stall;
      if (ok) begin
        in_taken++;
        sni_predict(w);
      end
      @(posedge clk);
    end while (!ok);
    items_sent++;
  endtask

  task automatic send_conn();
    foreach (conn_q[i]) send_word(conn_q[i]);
  endtask

  function automatic logic [7:0] host_char();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return (($urandom_range(0, 2) == 0) ? 8'd65 : 8'd97) + 8'(r);
    if (r < 36) return 8'd48 + 8'(r - 26);
    return "-";
  endfunction

  // flavor: 0 clean, 1 bad char, 2 trailing dot, 3 empty label, 4 long label,
  // 5 empty host, 6 corrupt byte, 7 wrong handshake type, 8 bad record type,
  // 9 longest legal host, 10 no server_name extension
  task automatic build_conn(input int flavor, input bit cut);
    logic [7:0] host[$], ent[$], ext[$], body[$], hs[$];
    int n, hl, chunk, lablen, idx;
    tls_sni_pkg::in_word_t w;
    conn_q = {};
    if (flavor == 9) begin
      for (int i = 0; i < 4; i++) begin
        if (i > 0) host.push_back(".");
        for (int j = 0; j < ((i == 3) ? 61 : 63); j++) host.push_back(host_char());
      end
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) host.push_back(".");
        lablen = (flavor == 4 && i == 0) ? 64 : $urandom_range(1, 8);
        for (int j = 0; j < lablen; j++) host.push_back(host_char());
      end
    end
    if (flavor == 1) host[$urandom_range(0, host.size() - 1)] = "_";
    if (flavor == 2) host.push_back(".");
    if (flavor == 3) host.push_front(".");
    if (flavor == 5) host = {};
    hl = host.size();
    if ($urandom_range(0, 3) == 0) ent = {8'd1, 8'd0, 8'd2, 8'($urandom), 8'($urandom)};
    ent = {ent, 8'd0, 8'(hl >> 8), 8'(hl), host};
    ent = {8'(ent.size() >> 8), 8'(ent.size()), ent};
    if ($urandom_range(0, 1) == 0 || flavor == 10) begin
      n = $urandom_range(0, 4);
      ext = {8'($urandom), 8'($urandom) | 8'd1, 8'd0, 8'(n)};
      repeat (n) ext.push_back(8'($urandom));
    end
    if (flavor != 10) ext = {ext, 8'd0, 8'd0, 8'(ent.size() >> 8), 8'(ent.size()), ent};
    body = {8'd3, 8'd3};
    repeat (32) body.push_back(8'($urandom));
    n = $urandom_range(0, 4);
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    n = 2 * $urandom_range(1, 3);
    body = {body, 8'd0, 8'(n)};
    repeat (n) body.push_back(8'($urandom));
    body = {body, 8'd1, 8'd0, 8'(ext.size() >> 8), 8'(ext.size()), ext};
    if (flavor == 6) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    hs = {(flavor == 7) ? 8'd2 : tls_sni_pkg::HS_CLIENT_HI, 8'd0, 8'(body.size() >> 8),
          8'(body.size()), body};
    w = '0;
    while (hs.size() > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        w.data_byte = tls_sni_pkg::REC_TYPE_HS; conn_q.push_back(w);
        w.data_byte = tls_sni_pkg::REC_MAJOR;   conn_q.push_back(w);
        w.data_byte = 8'd1;                     conn_q.push_back(w);
        w.data_byte = 8'd0;                     conn_q.push_back(w);
        conn_q.push_back(w);
      end
      chunk = $urandom_range(1, (hs.size() < 48) ? hs.size() : 48);
      w.data_byte = (flavor == 8) ? 8'd23 : tls_sni_pkg::REC_TYPE_HS; conn_q.push_back(w);
      w.data_byte = tls_sni_pkg::REC_MAJOR; conn_q.push_back(w);
      w.data_byte = 8'd1;                   conn_q.push_back(w);
      w.data_byte = 8'(chunk >> 8);         conn_q.push_back(w);
      w.data_byte = 8'(chunk);              conn_q.push_back(w);
      repeat (chunk) begin
        w.data_byte = hs.pop_front();
        conn_q.push_back(w);
      end
    end
    repeat ($urandom_range(0, 3)) begin
      w.data_byte = 8'($urandom);
      conn_q.push_back(w);
    end
    if (cut) begin
      idx = $urandom_range(1, conn_q.size());
      while (conn_q.size() > idx) void'(conn_q.pop_back());
      conn_q[$].last_available = 1'b1;
    end else if ($urandom_range(0, 1) == 0) conn_q[$].last_available = 1'b1;
    conn_q[0].first_byte = 1'b1;
  endtask

  task automatic build_noise();
    tls_sni_pkg::in_word_t w;
    conn_q = {};
    repeat ($urandom_range(1, 10)) begin
      w.first_byte = ($urandom_range(0, 7) == 0);
      w.data_byte = 8'($urandom);
      w.last_available = ($urandom_range(0, 5) == 0);
      conn_q.push_back(w);
    end
    conn_q[0].first_byte = 1'b1;
  endtask

  // ---- result side ----
  task automatic note_mismatch(string what, tls_sni_pkg::out_word_t e,
                               tls_sni_pkg::out_word_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: expected nv=%0d ch=%h vv=%0d vc=%0d, got nv=%0d ch=%h vv=%0d vc=%0d",
               $realtime, what, e.name_byte_valid, e.name_char, e.verdict_valid,
               e.verdict_code, a.name_byte_valid, a.name_char, a.verdict_valid,
               a.verdict_code);
  endtask

  always @(negedge clk) begin
    tls_sni_pkg::out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      out_taken++;
      if (expected_words.size() == 0) note_mismatch("unexpected word", '0, out_data);
      else begin
        e = expected_words.pop_front();
        if (out_data.name_byte_valid !== e.name_byte_valid ||
            out_data.name_char !== e.name_char ||
            out_data.verdict_valid !== e.verdict_valid ||
            out_data.verdict_code !== e.verdict_code)
          note_mismatch("word mismatch", e, out_data);
      end
    end
  end

  initial begin
    int n, c0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 12);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
        c0 = out_taken;
        while (out_taken == c0) @(posedge clk);
      end
    end
  end

  initial begin
    int idle, li, lo;
    idle = 0; li = 0; lo = 0;
    forever begin
      @(posedge clk);
      if (in_taken != li || out_taken != lo) idle = 0;
      else idle++;
      li = in_taken;
      lo = out_taken;
      if (idle >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---- tests ----
  task automatic test_record_headers();
    tls_sni_pkg::in_word_t w;
    w = '{1'b1, 8'd0, 1'b0};   send_word(w);
    w = '{1'b0, 8'd255, 1'b0}; send_word(w);
    w = '{1'b0, 8'd1, 1'b0};   send_word(w);
    w = '{1'b0, 8'd0, 1'b0};   send_word(w);
    w = '{1'b0, 8'd4, 1'b0};   send_word(w);
    w = '{1'b1, tls_sni_pkg::REC_TYPE_HS, 1'b0}; send_word(w);
    w = '{1'b0, tls_sni_pkg::REC_MAJOR, 1'b0};   send_word(w);
    w = '{1'b0, 8'd1, 1'b0};        send_word(w);
    w = '{1'b0, 8'd0, 1'b0};        send_word(w);
    w = '{1'b0, 8'd0, 1'b1};        send_word(w);
    w = '{1'b1, 8'd255, 1'b1};      send_word(w);
    w = '{1'b0, 8'd7, 1'b0};        send_word(w);
  endtask

  task automatic test_hello_flavors();
    for (int f = 0; f <= 10; f++) begin
      build_conn(f, 0);
      send_conn();
    end
    build_conn(0, 1);
    send_conn();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    build_conn(0, 0);
    send_conn();
  endtask

  task automatic test_random_streams();
    int start, r;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      r = $urandom_range(0, 19);
      if (r < 2) build_noise();
      else if (r < 5) build_conn($urandom_range(0, 10), 1);
      else if (r < 12) build_conn(0, 0);
      else build_conn($urandom_range(0, 10), 0);
      send_conn();
    end
    no_idle = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sni_reset();
    test_record_headers();
    test_hello_flavors();
    test_backpressure();
    test_random_streams();
    in_valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
